[src/gmnf_pkg.sv]
// Shared constants and types for the grid frontier search block.
`timescale 1ns / 1ps

package gmnf_pkg;

   // Grid size
   localparam int GRID_W = 16;
   localparam int GRID_H = 16;
   localparam int NCELLS = GRID_W * GRID_H;

   // Scan counter widths
   localparam int XW = (GRID_W > 2) ? $clog2(GRID_W) : 1;
   localparam int YW = (GRID_H > 2) ? $clog2(GRID_H) : 1;

   // Width of the input coordinate fields
   localparam int POS_W = 4;

   // Common coordinate width for compares, with one spare bit for +1
   localparam int MAXW = (XW > YW) ? XW : YW;
   localparam int CW   = ((MAXW > POS_W) ? MAXW : POS_W) + 1;

   // Manhattan distance width
   localparam int DW = CW + 1;

   // Stream word widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // Headings and wall directions
   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   // Turn offsets relative to the heading
   localparam logic [1:0] TURN_LEFT  = 2'd3;
   localparam logic [1:0] TURN_RIGHT = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

[src/grid_map_nearest_frontier.sv]
// Top level: map update and nearest frontier search over the grid.
//
//   channel | dir | words                 | handshake
//   --------+-----+-----------------------+--------------------------------
//   req_    | in  | one visit per word    | tvalid/tready, taken when both
//   rsp_    | out | one target per visit  | tvalid/tready, registered word
//
// A visit is taken only in idle. The map flags then rotate once through a
// single tap, one cell per cycle, past the shared distance and compare
// unit at the tap. The result word is then loaded into the output
// register, and the block returns to idle to take the next visit.
// Reset clears the reached and explored flags at once; no clearing pass.
// A result that is still waiting holds the next visit in its final state.
`timescale 1ns / 1ps

module grid_map_nearest_frontier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] pos_x, [7:4] pos_y, [9:8] facing, [10] wall_left,
   // [11] wall_front, [12] wall_right, [15:13] zero
   input  logic [gmnf_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] goal_x, [7:4] goal_y
   output logic [gmnf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] found
   output logic                               rsp_tuser
);

   import gmnf_pkg::*;

   // Input word fields
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [1:0]       facing;
   logic             wall_left;
   logic             wall_front;
   logic             wall_right;

   assign pos_x      = req_tdata[3:0];
   assign pos_y      = req_tdata[7:4];
   assign facing     = req_tdata[9:8];
   assign wall_left  = req_tdata[10];
   assign wall_front = req_tdata[11];
   assign wall_right = req_tdata[12];

   // Control and sequencer state
   state_type state_ff, state_in;
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;

   // Map flags, rotated through bit 0 during the scan
   logic [NCELLS-1:0] rch_ff, rch_in;
   logic [NCELLS-1:0] vis_ff, vis_in;

   // Visit latched at accept
   logic [CW-1:0] vx_ff, vx_in;
   logic [CW-1:0] vy_ff, vy_in;
   logic [3:0]    open_ff, open_in;
   logic          vok_ff, vok_in;

   // Robot position
   logic [CW-1:0] here_x_ff, here_x_in;
   logic [CW-1:0] here_y_ff, here_y_in;

   // Search results
   logic [DW-1:0] best_ff, best_in;
   logic [CW-1:0] bx_ff, bx_in;
   logic [CW-1:0] by_ff, by_in;
   logic          hit_ff, hit_in;
   logic [POS_W-1:0] goal_x_ff, goal_x_in;
   logic [POS_W-1:0] goal_y_ff, goal_y_in;

   // Output word register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_found_ff, rsp_found_in;

   // Handshake and strobes
   logic req_take;
   logic rsp_free;
   logic scan_last;

   // Visit decode
   logic [CW-1:0] px_ext;
   logic [CW-1:0] py_ext;
   logic          in_grid;

   // Scan tap
   logic [CW-1:0] cxe;
   logic [CW-1:0] cye;
   logic          self_hit;
   logic          reach_hit;
   logic          rch_new;
   logic          vis_new;
   logic [CW-1:0] dx;
   logic [CW-1:0] dy;
   logic [DW-1:0] mdist;
   logic          better;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign scan_last = (cx_ff == XW'(GRID_W - 1)) && (cy_ff == YW'(GRID_H - 1));

   // Decode the visit
   assign px_ext  = CW'(pos_x);
   assign py_ext  = CW'(pos_y);
   assign in_grid = (px_ext < CW'(GRID_W)) && (py_ext < CW'(GRID_H));

   // Cell under the tap and its flag update
   assign cxe       = CW'(cx_ff);
   assign cye       = CW'(cy_ff);
   assign self_hit  = vok_ff && (cxe == vx_ff) && (cye == vy_ff);
   assign reach_hit = vok_ff && (
         self_hit
      || (open_ff[DIR_N] && (vy_ff != '0) && (cxe == vx_ff) && (cye == vy_ff - 1'b1))
      || (open_ff[DIR_E] && (vx_ff < CW'(GRID_W - 1)) && (cye == vy_ff)
          && (cxe == vx_ff + 1'b1))
      || (open_ff[DIR_S] && (vy_ff < CW'(GRID_H - 1)) && (cxe == vx_ff)
          && (cye == vy_ff + 1'b1))
      || (open_ff[DIR_W] && (vx_ff != '0) && (cye == vy_ff) && (cxe == vx_ff - 1'b1)));
   assign rch_new = rch_ff[0] || reach_hit;
   assign vis_new = vis_ff[0] || self_hit;

   // Shared distance and compare unit
   assign dx     = (here_x_ff > cxe) ? (here_x_ff - cxe) : (cxe - here_x_ff);
   assign dy     = (here_y_ff > cye) ? (here_y_ff - cye) : (cye - here_y_ff);
   assign mdist  = DW'(dx) + DW'(dy);
   assign better = rch_new && !vis_new && (mdist != '0) && (mdist < best_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rch_in       = rch_ff;
      vis_in       = vis_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      open_in      = open_ff;
      vok_in       = vok_ff;
      here_x_in    = here_x_ff;
      here_y_in    = here_y_ff;
      best_in      = best_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      hit_in       = hit_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            // Latch the visit and open the sides with no sensed wall
            if (req_take) begin
               vx_in   = px_ext;
               vy_in   = py_ext;
               vok_in  = in_grid;
               open_in = '0;
               if (!wall_left) begin
                  open_in[facing + TURN_LEFT] = 1'b1;
               end
               if (!wall_front) begin
                  open_in[facing] = 1'b1;
               end
               if (!wall_right) begin
                  open_in[facing + TURN_RIGHT] = 1'b1;
               end
               if (in_grid) begin
                  here_x_in = px_ext;
                  here_y_in = py_ext;
               end
               cx_in   = '0;
               cy_in   = '0;
               best_in = '1;
               hit_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            // Rotate the flags one cell and fold the updated cell back in
            rch_in = {rch_new, rch_ff[NCELLS-1:1]};
            vis_in = {vis_new, vis_ff[NCELLS-1:1]};
            if (better) begin
               best_in = mdist;
               bx_in   = cxe;
               by_in   = cye;
               hit_in  = 1'b1;
            end
            // Advance columns inner, rows outer
            if (cx_ff == XW'(GRID_W - 1)) begin
               cx_in = '0;
               cy_in = cy_ff + 1'b1;
            end else begin
               cx_in = cx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // Load the result word once the output register is free
            if (rsp_free) begin
               if (hit_ff) begin
                  goal_x_in = bx_ff[POS_W-1:0];
                  goal_y_in = by_ff[POS_W-1:0];
               end
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_data_in  = hit_ff ? {by_ff[POS_W-1:0], bx_ff[POS_W-1:0]}
                                     : {goal_y_ff, goal_x_ff};
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rch_ff       <= '0;
         vis_ff       <= '0;
         here_x_ff    <= '0;
         here_y_ff    <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         vok_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         best_ff      <= '1;
      end else begin
         state_ff     <= state_in;
         rch_ff       <= rch_in;
         vis_ff       <= vis_in;
         here_x_ff    <= here_x_in;
         here_y_ff    <= here_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         rsp_valid_ff <= rsp_valid_in;
         vok_ff       <= vok_in;
         hit_ff       <= hit_in;
         best_ff      <= best_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      open_ff      <= open_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   // A taken visit always starts a scan
   a_take_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN))
      else $error("visit taken without starting a scan");

   // A found target is never the robot's own cell
   a_goal_not_here: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && hit_ff |-> ((bx_ff != here_x_ff) || (by_ff != here_y_ff)))
      else $error("target equals robot position");

   // The hit flag tracks whether the best distance was ever lowered
   a_hit_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (hit_ff == (best_ff != '1)))
      else $error("hit flag and best distance disagree");

   // The best distance never becomes zero
   a_best_nonzero: assert property (@(posedge clock) disable iff (reset)
      best_ff != '0)
      else $error("zero distance recorded as best");

endmodule

[tb/grid_map_nearest_frontier_tb.sv]
// Testbench for grid_map_nearest_frontier: visit stream against a map-based target predictor.
`timescale 1ns / 1ps

module grid_map_nearest_frontier_tb;
   import gmnf_pkg::*;

   localparam int NO_DIST        = 32'h3FFF_FFFF;
   localparam int RANDOM_VISITS  = 1530;
   localparam int GAP_MAX        = 6;
   localparam int BURST_MAX      = 8;
   localparam int STALL_MAX      = 40;
   localparam int STALL_PHASE    = 2500;
   localparam int SCAN_CYCLES    = NCELLS + 2;
   localparam int IDLE_LIMIT     = 4 * (SCAN_CYCLES + STALL_MAX + GAP_MAX);

   // Visit word, lowest field last in the list
   typedef struct packed {
      logic       wall_right;
      logic       wall_front;
      logic       wall_left;
      logic [1:0] facing;
      logic [3:0] pos_y;
      logic [3:0] pos_x;
   } visit_type;

   typedef struct packed {
      logic       found;
      logic [3:0] goal_x;
      logic [3:0] goal_y;
   } target_type;

   typedef struct {
      visit_type  v;
      bit         typed;
      target_type want;
   } plan_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;

   // Predictor state
   logic [3:0] wall_map [NCELLS];
   bit         explored [NCELLS];
   bit         unreached [NCELLS];
   logic [3:0] robot_x, robot_y;
   logic [3:0] aim_x, aim_y;
   bit         last_found;

   target_type   targets_due [$];
   plan_row_type directed_visits [$];
   target_type   want;
   int         mismatches = 0;
   int         idle_cycles = 0;
   int         stall_left = 0;
   int         phase_count = 0;
   bit         stalls_on = 1'b1;
   int         burst_left = 0;

   grid_map_nearest_frontier uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Clear the map: border walls only, nothing reached or explored
   function automatic void clear_map();
      for (int c = 0; c < NCELLS; c++) begin
         wall_map[c]  = 4'b0000;
         explored[c]  = 1'b0;
         unreached[c] = 1'b1;
      end
      for (int x = 0; x < GRID_W; x++) begin
         wall_map[x][DIR_N] = 1'b1;
         wall_map[(GRID_H - 1) * GRID_W + x][DIR_S] = 1'b1;
      end
      for (int y = 0; y < GRID_H; y++) begin
         wall_map[y * GRID_W][DIR_W] = 1'b1;
         wall_map[y * GRID_W + GRID_W - 1][DIR_E] = 1'b1;
      end
      robot_x    = '0;
      robot_y    = '0;
      aim_x      = '0;
      aim_y      = '0;
      last_found = 1'b0;
   endfunction

   // Mark the neighbor on one side reachable when it lies in the grid
   function automatic void open_neighbor(int x, int y, logic [1:0] side);
      case (side)
         DIR_N: if (y > 0) unreached[(y - 1) * GRID_W + x] = 1'b0;
         DIR_E: if (x < GRID_W - 1) unreached[y * GRID_W + x + 1] = 1'b0;
         DIR_S: if (y < GRID_H - 1) unreached[(y + 1) * GRID_W + x] = 1'b0;
         default: if (x > 0) unreached[y * GRID_W + x - 1] = 1'b0;
      endcase
   endfunction

   // Apply one visit to the map and pick the nearest frontier cell
   function automatic target_type nearest_frontier(visit_type v);
      int x, y, idx, best, mdist, bx, by, dx, dy;
      logic [1:0] side_l, side_r;
      bit hit;
      target_type t;
      x    = v.pos_x;
      y    = v.pos_y;
      best = NO_DIST;
      bx   = 0;
      by   = 0;
      hit  = 1'b0;
      if (x < GRID_W && y < GRID_H) begin
         idx    = y * GRID_W + x;
         side_l = v.facing + TURN_LEFT;
         side_r = v.facing + TURN_RIGHT;
         // wall map is updated but never read by the search
         wall_map[idx][side_l]   = v.wall_left;
         wall_map[idx][v.facing] = v.wall_front;
         wall_map[idx][side_r]   = v.wall_right;
         if (!v.wall_left)  open_neighbor(x, y, side_l);
         if (!v.wall_right) open_neighbor(x, y, side_r);
         if (!v.wall_front) open_neighbor(x, y, v.facing);
         explored[idx]  = 1'b1;
         unreached[idx] = 1'b0;
         robot_x = x[3:0];
         robot_y = y[3:0];
      end
      // Scan rows outer, columns inner; strict compare keeps the first tie
      for (int cy = 0; cy < GRID_H; cy++) begin
         for (int cx = 0; cx < GRID_W; cx++) begin
            if (!explored[cy * GRID_W + cx] && !unreached[cy * GRID_W + cx]) begin
               dx    = (robot_x > cx) ? robot_x - cx : cx - robot_x;
               dy    = (robot_y > cy) ? robot_y - cy : cy - robot_y;
               mdist = dx + dy;
               if (mdist != 0 && mdist < best) begin
                  best = mdist;
                  bx   = cx;
                  by   = cy;
                  hit  = 1'b1;
               end
            end
         end
      end
      if (hit) begin
         aim_x = bx[3:0];
         aim_y = by[3:0];
      end
      last_found = hit;
      t.found  = hit;
      t.goal_x = aim_x;
      t.goal_y = aim_y;
      return t;
   endfunction

   function automatic void plan_visit(int x, int y, logic [1:0] f, int l, int fr, int r,
                                      int typed = 0, int ef = 0, int ex = 0, int ey = 0);
      plan_row_type row;
      row.v.pos_x      = 4'(x);
      row.v.pos_y      = 4'(y);
      row.v.facing     = f;
      row.v.wall_left  = 1'(l);
      row.v.wall_front = 1'(fr);
      row.v.wall_right = 1'(r);
      row.typed        = 1'(typed);
      row.want.found   = 1'(ef);
      row.want.goal_x  = 4'(ex);
      row.want.goal_y  = 4'(ey);
      directed_visits.push_back(row);
   endfunction

   // Random visit: mostly a robot walking or heading for its target, some jumps
   function automatic visit_type pick_visit();
      visit_type v;
      int roll, x, y;
      logic [1:0] d;
      roll = $urandom_range(0, 99);
      x    = robot_x;
      y    = robot_y;
      d    = 2'($urandom_range(0, 3));
      v.facing = 2'($urandom_range(0, 3));
      if (roll < 40 && last_found) begin
         x = aim_x;
         y = aim_y;
      end else if (roll < 85) begin
         // step one cell, turning back at the edge
         if ((d == DIR_N && y == 0) || (d == DIR_S && y == GRID_H - 1) ||
             (d == DIR_W && x == 0) || (d == DIR_E && x == GRID_W - 1))
            d = d ^ 2'b10;
         case (d)
            DIR_N: y = y - 1;
            DIR_E: x = x + 1;
            DIR_S: y = y + 1;
            default: x = x - 1;
         endcase
         v.facing = d;
      end else begin
         x = $urandom_range(0, 15);
         y = $urandom_range(0, 15);
      end
      v.pos_x = 4'(x);
      v.pos_y = 4'(y);
      if (roll >= 85) begin
         v.wall_left  = 1'($urandom_range(0, 1));
         v.wall_front = 1'($urandom_range(0, 1));
         v.wall_right = 1'($urandom_range(0, 1));
      end else begin
         // lean toward walls so the frontier lasts longer
         v.wall_left  = ($urandom_range(0, 4) < 3);
         v.wall_front = ($urandom_range(0, 4) < 3);
         v.wall_right = ($urandom_range(0, 4) < 3);
      end
      return v;
   endfunction

   // Offer one visit word, wait for the handshake, then queue its target
   task automatic send_visit(visit_type v, bit typed, target_type typed_want);
      target_type t;
      int gap;
      req_tdata  <= {3'b000, v};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      t = nearest_frontier(v);
      targets_due.push_back(typed ? typed_want : t);
      // pace the sender in bursts
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(0, GAP_MAX);
         burst_left = $urandom_range(1, BURST_MAX);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Check result words, stall the receiver, watch for a hang
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (targets_due.size() == 0) begin
            $display("%0t: unexpected result word: found %0b goal (%0d,%0d)",
                     $time, rsp_tuser, rsp_tdata[3:0], rsp_tdata[7:4]);
            mismatches++;
         end else begin
            want = targets_due.pop_front();
            if (rsp_tuser !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[3:0] !== want.goal_x) begin
               $display("%0t: goal_x expected %0d actual %0d", $time, want.goal_x,
                        rsp_tdata[3:0]);
               mismatches++;
            end
            if (rsp_tdata[7:4] !== want.goal_y) begin
               $display("%0t: goal_y expected %0d actual %0d", $time, want.goal_y,
                        rsp_tdata[7:4]);
               mismatches++;
            end
         end
      end

      // alternate phases with and without stalls
      phase_count++;
      if (phase_count == STALL_PHASE) begin
         phase_count = 0;
         stalls_on   = !stalls_on;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (stalls_on && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, STALL_MAX);
      end

      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clear_map();

      // Directed visits; typed targets where they follow at a glance
      plan_visit(0, 0, DIR_N, 1, 1, 1, 1, 0, 0, 0);   // boxed in: nothing found
      plan_visit(0, 0, DIR_S, 1, 0, 1, 1, 1, 0, 1);   // open ahead only
      plan_visit(15, 15, DIR_E, 0, 0, 0, 1, 1, 15, 14); // corner, two sides off grid
      plan_visit(15, 0, DIR_W, 0, 0, 0, 1, 1, 14, 0); // tie, row 0 wins
      plan_visit(0, 15, DIR_N, 0, 0, 0, 1, 1, 0, 14); // tie, upper row wins
      plan_visit(7, 8, DIR_N, 0, 0, 0);
      plan_visit(7, 8, DIR_E, 1, 0, 1);
      plan_visit(7, 8, DIR_S, 0, 1, 0);
      plan_visit(7, 8, DIR_W, 1, 1, 0);
      plan_visit(8, 7, DIR_S, 0, 1, 1);
      plan_visit(8, 7, DIR_N, 1, 0, 0);
      plan_visit(9, 9, DIR_E, 0, 0, 1);
      plan_visit(0, 7, DIR_W, 0, 1, 1);
      plan_visit(15, 7, DIR_E, 1, 1, 1);
      plan_visit(7, 0, DIR_N, 0, 0, 0);
      plan_visit(7, 15, DIR_S, 1, 0, 1);
      plan_visit(15, 15, DIR_W, 1, 1, 1);
      plan_visit(0, 0, DIR_E, 0, 1, 0);

      // Hold reset, then release
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_visits[i])
         send_visit(directed_visits[i].v, directed_visits[i].typed, directed_visits[i].want);
      for (int i = 0; i < RANDOM_VISITS; i++)
         send_visit(pick_visit(), 1'b0, '0);
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any extra word
      while (targets_due.size() != 0) @(posedge clock);
      repeat (SCAN_CYCLES + 8) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
